// ----- rtl/coordinated_turn_predict_defines.svh -----
// ----------------------------------------------------------------------------
// coordinated turn predictor assertion macros
// shared assertion helpers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef COORDINATED_TURN_PREDICT_DEFINES_SVH
`define COORDINATED_TURN_PREDICT_DEFINES_SVH

`ifndef SYNTHESIS
`define CTP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctp assertion failed");
`define CTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctp assertion failed");
`else
`define CTP_ASSERT_SAME(label, ante, cons)
`define CTP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/ctp_pkg.sv -----
// ----------------------------------------------------------------------------
// ctp_pkg
// constants, tables, types and the saturation helper of the coordinated turn predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

  localparam int TWO_PI          = 411775;
  localparam int PI_Q            = 205887;
  localparam int HALF_PI         = 102944;
  localparam int RECIP_TWO_PI    = 10430;
  localparam int CORDIC_GAIN     = 652032874;
  localparam int STEP_TIME_RESET = 6554;
  localparam int ATAN_ENTRIES    = 30;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] speed;
    logic signed [31:0] heading;
    logic signed [31:0] turn_rate;
    logic signed [40:0] dw;
    logic               neg;
  } carry_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [44:0] v);
    sat_t res;
    if (v > 45'sd2147483647) begin
      res.ovf = 1'b1;
      res.val = 32'sh7FFFFFFF;
    end else if (v < -45'sd2147483648) begin
      res.ovf = 1'b1;
      res.val = 32'sh80000000;
    end else begin
      res.ovf = 1'b0;
      res.val = v[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/coordinated_turn_predict.sv -----
// ----------------------------------------------------------------------------
// coordinated_turn_predict
// coordinated-turn one-step state prediction with its jacobian entries
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid / in_stall carries one target state per item
//   (pos_x, pos_y, speed, heading, turn_rate, all signed Q16.16).
//   output channel out_valid / out_stall carries the predicted state, the
//   four jacobian entries and the overflow flag for that item.
//   step_time (dt) is written through cfg_wr_en / cfg_wr_data while idle.
//   the pipe has five stages of heading reduction, one stage per cordic
//   rotation and three stages of multiply, round and saturate.
//   one item per cycle is taken while in_stall is low; each stage holds
//   only while the stage after it holds a waiting item, so bubbles are
//   squeezed out under stall. a stalled output holds its item; in_stall
//   rises once every stage is full and out_stall is high.
//   reset empties the pipeline and loads step_time with 6554 (about 0.1 s).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "coordinated_turn_predict_defines.svh"

module coordinated_turn_predict
  import ctp_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_wr_en,
  input  wire         [23:0] cfg_wr_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  signed [31:0] pos_x,
  input  wire  signed [31:0] pos_y,
  input  wire  signed [31:0] speed,
  input  wire  signed [31:0] heading,
  input  wire  signed [31:0] turn_rate,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] next_x,
  output logic signed [31:0] next_y,
  output logic signed [31:0] next_speed,
  output logic signed [31:0] next_heading,
  output logic signed [31:0] next_turn_rate,
  output logic signed [31:0] jac_x_speed,
  output logic signed [31:0] jac_x_heading,
  output logic signed [31:0] jac_y_speed,
  output logic signed [31:0] jac_y_heading,
  output logic               overflow
);

  localparam int NC   = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int NST  = NC + 8;
  localparam int ST_F = NC + 5;
  localparam int ST_G = NC + 6;

  localparam logic signed [14:0] RECIP_S  = 15'(RECIP_TWO_PI);
  localparam logic signed [19:0] TWO_PI_S = 20'(TWO_PI);

  logic        [23:0] step_time;
  logic signed [24:0] dt_s;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  carry_t cr      [NST];
  carry_t cr_next [NST];

  logic signed [45:0] hp;
  logic signed [56:0] dwp;
  logic signed [56:0] dw_sum;
  logic signed [13:0] q_est;
  logic signed [33:0] m;
  logic signed [33:0] r0;
  logic signed [19:0] r1;
  logic signed [19:0] r1_next;
  logic signed [19:0] r2;
  logic signed [19:0] r3;
  logic               neg_e;

  logic signed [33:0] cx [NC+1];
  logic signed [33:0] cy [NC+1];
  logic signed [33:0] cz [NC+1];

  logic signed [33:0] c_f;
  logic signed [33:0] s_f;
  logic signed [57:0] pc;
  logic signed [57:0] ps;
  logic signed [57:0] pc_sum;
  logic signed [57:0] ps_sum;
  logic signed [27:0] dtc_g;
  logic signed [27:0] dts_g;
  logic signed [27:0] dtc;
  logic signed [27:0] dts;
  logic signed [59:0] pvc;
  logic signed [59:0] pvs;
  logic signed [59:0] pvc_sum;
  logic signed [59:0] pvs_sum;
  logic signed [43:0] dvc;
  logic signed [43:0] dvs;
  sat_t               sx;
  sat_t               sy;
  sat_t               sh;
  sat_t               sjxs;
  sat_t               sjxh;
  sat_t               sjys;
  sat_t               sjyh;

  assign dt_s = $signed({1'b0, step_time});

  // step time register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= 24'(STEP_TIME_RESET);
    end else if (cfg_wr_en) begin
      step_time <= cfg_wr_data;
    end
  end

  // stage enables, a stage moves when empty or when the next one moves
  always_comb begin
    en[NST-1] = !v[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // items carried along the pipe
  assign dw_sum = dwp + 57'sd32768;

  always_comb begin
    cr_next[0].pos_x     = pos_x;
    cr_next[0].pos_y     = pos_y;
    cr_next[0].speed     = speed;
    cr_next[0].heading   = heading;
    cr_next[0].turn_rate = turn_rate;
    cr_next[0].dw        = '0;
    cr_next[0].neg       = 1'b0;
    for (int i = 1; i < NST; i++) begin
      cr_next[i] = cr[i-1];
    end
    cr_next[1].dw  = dw_sum[56:16];
    cr_next[4].neg = neg_e;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (en[i]) begin
        cr[i] <= cr_next[i];
      end
    end
  end

  // heading reduction modulo two pi, then fold into plus or minus half pi
  assign q_est = hp[45:32];

  always_comb begin
    if (r0[33]) begin
      r1_next = 20'(r0 + TWO_PI);
    end else if (r0 >= TWO_PI) begin
      r1_next = 20'(r0 - TWO_PI);
    end else begin
      r1_next = 20'(r0);
    end
  end

  always_comb begin
    r2    = (r1 > PI_Q) ? 20'(r1 - TWO_PI) : r1;
    r3    = r2;
    neg_e = 1'b0;
    if (r2 > HALF_PI) begin
      r3    = 20'(r2 - PI_Q);
      neg_e = 1'b1;
    end else if (r2 < -HALF_PI) begin
      r3    = 20'(r2 + PI_Q);
      neg_e = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hp  <= heading * RECIP_S;
      dwp <= dt_s * turn_rate;
    end
    if (en[1]) begin
      m <= q_est * TWO_PI_S;
    end
    if (en[2]) begin
      r0 <= 34'(cr[1].heading) - m;
    end
    if (en[3]) begin
      r1 <= r1_next;
    end
    if (en[4]) begin
      cx[0] <= 34'(CORDIC_GAIN);
      cy[0] <= '0;
      cz[0] <= 34'(r3) <<< 14;
    end
  end

  // rotation stages, one per cordic step
  for (genvar g = 0; g < NC; g++) begin : g_cordic
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] ang;

    assign dx  = cy[g] >>> g;
    assign dy  = cx[g] >>> g;
    assign ang = $signed({2'b00, ATAN_Q30[g]});

    always_ff @(posedge clk) begin
      if (en[5+g]) begin
        if (!cz[g][33]) begin
          cx[g+1] <= cx[g] - dx;
          cy[g+1] <= cy[g] + dy;
          cz[g+1] <= cz[g] - ang;
        end else begin
          cx[g+1] <= cx[g] + dx;
          cy[g+1] <= cy[g] - dy;
          cz[g+1] <= cz[g] + ang;
        end
      end
    end
  end

  // scale by dt, then by speed
  assign c_f     = cr[ST_F-1].neg ? -cx[NC] : cx[NC];
  assign s_f     = cr[ST_F-1].neg ? -cy[NC] : cy[NC];
  assign pc_sum  = pc + 58'sd536870912;
  assign ps_sum  = ps + 58'sd536870912;
  assign dtc     = pc_sum[57:30];
  assign dts     = ps_sum[57:30];
  assign pvc_sum = pvc + 60'sd32768;
  assign pvs_sum = pvs + 60'sd32768;
  assign dvc     = pvc_sum[59:16];
  assign dvs     = pvs_sum[59:16];

  assign sx   = sat32(45'(cr[ST_G].pos_x) + 45'(dvc));
  assign sy   = sat32(45'(cr[ST_G].pos_y) + 45'(dvs));
  assign sh   = sat32(45'(cr[ST_G].heading) + 45'(cr[ST_G].dw));
  assign sjxs = sat32(45'(dtc_g));
  assign sjxh = sat32(-45'(dvs));
  assign sjys = sat32(45'(dts_g));
  assign sjyh = sat32(45'(dvc));

  always_ff @(posedge clk) begin
    if (en[ST_F]) begin
      pc <= dt_s * c_f;
      ps <= dt_s * s_f;
    end
    if (en[ST_G]) begin
      dtc_g <= dtc;
      dts_g <= dts;
      pvc   <= cr[ST_F].speed * dtc;
      pvs   <= cr[ST_F].speed * dts;
    end
    if (en[NST-1]) begin
      next_x        <= sx.val;
      next_y        <= sy.val;
      next_heading  <= sh.val;
      jac_x_speed   <= sjxs.val;
      jac_x_heading <= sjxh.val;
      jac_y_speed   <= sjys.val;
      jac_y_heading <= sjyh.val;
      overflow      <= sx.ovf | sy.ovf | sh.ovf | sjxs.ovf | sjxh.ovf | sjys.ovf
                       | sjyh.ovf;
    end
  end

  assign next_speed     = cr[NST-1].speed;
  assign next_turn_rate = cr[NST-1].turn_rate;

  // checks
  `CTP_ASSERT_SAME(a_stall_source, in_stall, (&v) && out_stall)
  `CTP_ASSERT_SAME(a_mod_range, v[3], (r1 >= 0) && (r1 < TWO_PI))
  `CTP_ASSERT_SAME(a_fold_range, v[4],
                   (cz[0] <= (34'sd102944 <<< 14)) && (cz[0] >= -(34'sd102944 <<< 14)))
  `CTP_ASSERT_SAME(a_jac_bound, out_valid,
                   (jac_x_speed <= 32'sd33554432) && (jac_x_speed >= -32'sd33554432))
  `CTP_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(next_x))

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// coordinated turn predictor testbench
// drives target states with random idling and output stall, predicts each
// result from a bit-exact model of the fixed-point arithmetic and compares
// every field in order; dt is changed between phases while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ctp_pkg::*;

  typedef struct packed {
    logic [31:0] nx, ny, nv, nh, nw, jxs, jxh, jys, jyh;
    logic        ovf;
  } pred_t;

  class pred_board;
    pred_t pending[$];
    int    mismatches;
    int    checked;
    logic [23:0] dt;

    function automatic longint rshift_round(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, ref bit o);
      if (v > 64'sd2147483647) begin
        o = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        o = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function void note_state(logic [31:0] px, logic [31:0] py, logic [31:0] v,
                             logic [31:0] h, logic [31:0] w);
      longint r, x, y, z, dx, dy, c, s, dtc, dts, dvc, dvs, dw, sv, t;
      bit neg, o;
      pred_t p;
      neg = 0;
      o = 0;
      r = longint'($signed(h)) % TWO_PI;
      if (r < 0) r += TWO_PI;
      if (r > PI_Q) r -= TWO_PI;
      if (r > HALF_PI) begin
        r -= PI_Q;
        neg = 1;
      end else if (r < -HALF_PI) begin
        r += PI_Q;
        neg = 1;
      end
      x = CORDIC_GAIN;
      y = 0;
      z = r * 16384;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
        end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
      t = longint'(dt);
      dtc = rshift_round(t * c, 30);
      dts = rshift_round(t * s, 30);
      sv = longint'($signed(v));
      dvc = rshift_round(sv * dtc, 16);
      dvs = rshift_round(sv * dts, 16);
      dw = rshift_round(t * longint'($signed(w)), 16);
      p.nx = 32'(clip(longint'($signed(px)) + dvc, o));
      p.ny = 32'(clip(longint'($signed(py)) + dvs, o));
      p.nv = v;
      p.nh = 32'(clip(longint'($signed(h)) + dw, o));
      p.nw = w;
      p.jxs = 32'(clip(dtc, o));
      p.jxh = 32'(clip(-dvs, o));
      p.jys = 32'(clip(dts, o));
      p.jyh = 32'(clip(dvc, o));
      p.ovf = o;
      pending.push_back(p);
    endfunction

    function void check_result(pred_t a);
      pred_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (a != e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp %h %h %h %h %h %h %h %h %h %b",
            e.nx, e.ny, e.nv, e.nh, e.nw, e.jxs, e.jxh, e.jys, e.jyh, e.ovf);
          $display("          got %h %h %h %h %h %h %h %h %h %b",
            a.nx, a.ny, a.nv, a.nh, a.nw, a.jxs, a.jxh, a.jys, a.jyh, a.ovf);
        end
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_wr_en = 0;
  logic [23:0] cfg_wr_data = 0;
  logic in_valid = 0, out_stall = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0, speed = 0, heading = 0, turn_rate = 0;
  wire in_stall, out_valid, overflow;
  wire signed [31:0] next_x, next_y, next_speed, next_heading, next_turn_rate;
  wire signed [31:0] jac_x_speed, jac_x_heading, jac_y_speed, jac_y_heading;

  coordinated_turn_predict i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .pos_x(pos_x), .pos_y(pos_y),
    .speed(speed), .heading(heading), .turn_rate(turn_rate),
    .out_valid(out_valid), .out_stall(out_stall), .next_x(next_x), .next_y(next_y),
    .next_speed(next_speed), .next_heading(next_heading),
    .next_turn_rate(next_turn_rate), .jac_x_speed(jac_x_speed),
    .jac_x_heading(jac_x_heading), .jac_y_speed(jac_y_speed),
    .jac_y_heading(jac_y_heading), .overflow(overflow)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  pred_board board = new();
  bit   quiet = 0;
  int   cycles = 0;
  int   items = 0;
  int   stall_left = 0;

  // output side: check accepted results and apply bursty stall
  always @(posedge clk) begin
    pred_t a;
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      a.nx = next_x; a.ny = next_y; a.nv = next_speed; a.nh = next_heading;
      a.nw = next_turn_rate; a.jxs = jac_x_speed; a.jxh = jac_x_heading;
      a.jys = jac_y_speed; a.jyh = jac_y_heading; a.ovf = overflow;
      board.check_result(a);
    end
    if (quiet) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 131072) - 65536;
      3: return $urandom_range(0, 1 << 22) - (1 << 21);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_state(logic [31:0] px, logic [31:0] py, logic [31:0] v,
                            logic [31:0] h, logic [31:0] w);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    pos_x <= px; pos_y <= py; speed <= v; heading <= h; turn_rate <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_state(px, py, v, h, w);
    items++;
  endtask

  task automatic drain_and_set(logic [23:0] dt);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= dt;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.dt = dt;
  endtask

  task automatic random_phase(int n);
    repeat (n) send_state(pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
  endtask

  initial begin
    board.dt = 24'(STEP_TIME_RESET);
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, quadrant boundaries, wrap of heading
    send_state(0, 0, 0, 0, 0);
    send_state(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_state(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_state(100 << 16, -(50 << 16), 10 << 16, HALF_PI, 1 << 16);
    send_state(0, 0, 10 << 16, HALF_PI + 1, 0);
    send_state(0, 0, 10 << 16, PI_Q, 0);
    send_state(0, 0, 10 << 16, PI_Q + 1, 0);
    send_state(0, 0, 10 << 16, -HALF_PI - 1, 0);
    send_state(0, 0, 10 << 16, TWO_PI, 0);
    send_state(0, 0, 10 << 16, -TWO_PI, 0);
    send_state(0, 0, -(10 << 16), 3 * TWO_PI + 7, -(2 << 16));
    send_state(32'h7FFF0000, 0, 32'h7FFFFFFF, 0, 0);
    drain_and_set(24'hFFFFFF);
    send_state(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_state(0, 0, 32'h80000000, HALF_PI, 32'h80000000);
    send_state(0, 0, 1 << 16, 0, 1 << 16);
    random_phase(100);
    drain_and_set(24'd0);
    send_state(5, 6, 7, 8, 9);
    random_phase(80);
    drain_and_set(24'd1);
    random_phase(80);
    drain_and_set(24'($urandom));
    random_phase(90);
    drain_and_set(24'(STEP_TIME_RESET));
    quiet = 1;
    random_phase(90);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    $display("sent %0d target states over five dt settings, %0d results checked",
             items, board.checked);
    if (board.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("tb failed");
    end
    $finish;
  end
endmodule
